@@ rtl/crc16_x25_frame_builder_top_macros.svh @@
// Assertion macros used by the frame builder checker.
`ifndef CRC16_X25_FRAME_BUILDER_TOP_MACROS_SVH
`define CRC16_X25_FRAME_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CXF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define CXF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cxf_pkg.sv @@
// Types, constants and the CRC step function of the frame builder.
`default_nettype none

package cxf_pkg;

  localparam int unsigned HEADER_BYTES = 35;

  localparam logic [5:0] HDR_LAST       = 6'(HEADER_BYTES - 1);
  localparam logic [5:0] POS_PROTO      = 6'd1;
  localparam logic [5:0] POS_VER        = 6'd2;
  localparam logic [5:0] POS_CMD_LO     = 6'd3;
  localparam logic [5:0] POS_CMD_HI     = 6'd4;
  localparam logic [5:0] POS_MAC_LAST   = 6'd10;
  localparam logic [5:0] POS_CLASS_LAST = 6'd18;
  localparam logic [5:0] POS_DATA       = 6'd19;
  localparam logic [5:0] POS_WIFI       = 6'd20;
  localparam logic [5:0] POS_SEQ_LO     = 6'd21;
  localparam logic [5:0] POS_SEQ_HI     = 6'd24;
  localparam logic [5:0] POS_RESV_LAST  = 6'd32;
  localparam logic [5:0] POS_LEN_LO     = 6'd33;

  localparam logic [7:0]  SYNC_BYTE  = 8'hF2;
  localparam logic [7:0]  PROTO_BYTE = 8'h42;
  localparam logic [7:0]  VER_BYTE   = 8'h02;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAC   = 2'd0,
    CFG_CLASS = 2'd1,
    CFG_RESV  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_BODY,
    ST_TAIL
  } state_e;

  typedef enum logic [1:0] {
    TL_BODY_LO  = 2'd0,
    TL_BODY_HI  = 2'd1,
    TL_FRAME_LO = 2'd2,
    TL_FRAME_HI = 2'd3
  } tail_slot_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] command_word;
    logic [7:0]  data_state;
    logic [7:0]  wifi_state;
    logic [31:0] sequence_number;
    logic [15:0] body_length;
    logic [7:0]  body_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       overrun;
  } out_word_t;

  typedef struct packed {
    logic [47:0] device_mac;
    logic [63:0] device_class;
    logic [63:0] reserved_word;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/crc16_x25_frame_builder_top.sv @@
// Top level of the CRC-16/X.25 frame builder.
//
// Input channel: in_valid_i / in_stall_o carry one word, either a start word
// (mode 0, header fields) or a body word (mode 1, one payload byte).
// Output channel: out_valid_o / out_stall_i carry one frame byte per word.
// A start word yields the 35-byte header, plus two zero bytes and the frame
// check when the body length is zero (39 bytes). A body word yields its byte,
// and the last one also the body check and the frame check (5 bytes). A body
// word with no open packet yields one byte flagged as overrun.
// A taken word is registered first; its first byte then passes the output register.
// Throughput: one output byte per cycle while the output is not stalled; the
// input is held off while a word still has bytes to send, so single-byte body
// words flow at one per cycle. The single output register sets the rate.
// Reset clears the sequencer and the config registers and sets the CRCs to CRC_INIT.
// A stalled output holds its byte; the sequencer waits and backs up input.
// Config writes take effect on the next cycle and belong to idle periods.
`default_nettype none

module crc16_x25_frame_builder_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cxf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cxf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire cxf_pkg::in_word_t              in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output cxf_pkg::out_word_t                  out_word_o
);
  import cxf_pkg::*;

  cfg_t cfg;

  cxf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cxf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

@@ rtl/cxf_cfg_regs.sv @@
// Configuration registers of the frame builder.
`default_nettype none

module cxf_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cxf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cxf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output cxf_pkg::cfg_t                       cfg_o
);
  import cxf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAC:   cfg_d.device_mac    = cfg_wdata_i[47:0];
        CFG_CLASS: cfg_d.device_class  = cfg_wdata_i;
        CFG_RESV:  cfg_d.reserved_word = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/cxf_hdr_sel.sv @@
// Header byte selection by position.
`default_nettype none

module cxf_hdr_sel (
  input  wire logic [5:0]        idx_i,
  input  wire cxf_pkg::in_word_t item_i,
  input  wire cxf_pkg::cfg_t     cfg_i,
  output logic [7:0]             byte_o
);
  import cxf_pkg::*;

  logic [2:0] mac_sel, cls_sel, res_sel;
  logic [1:0] seq_sel;

  assign mac_sel = 3'(POS_MAC_LAST - idx_i);
  assign cls_sel = 3'(POS_CLASS_LAST - idx_i);
  assign res_sel = 3'(POS_RESV_LAST - idx_i);
  assign seq_sel = 2'(idx_i - POS_SEQ_LO);

  always_comb begin
    byte_o = '0;
    priority if (idx_i < POS_PROTO) begin
      byte_o = SYNC_BYTE;
    end else if (idx_i == POS_PROTO) begin
      byte_o = PROTO_BYTE;
    end else if (idx_i == POS_VER) begin
      byte_o = VER_BYTE;
    end else if (idx_i == POS_CMD_LO) begin
      byte_o = item_i.command_word[7:0];
    end else if (idx_i == POS_CMD_HI) begin
      byte_o = item_i.command_word[15:8];
    end else if (idx_i <= POS_MAC_LAST) begin
      byte_o = cfg_i.device_mac[{mac_sel, 3'b000} +: 8];
    end else if (idx_i <= POS_CLASS_LAST) begin
      byte_o = cfg_i.device_class[{cls_sel, 3'b000} +: 8];
    end else if (idx_i == POS_DATA) begin
      byte_o = item_i.data_state;
    end else if (idx_i == POS_WIFI) begin
      byte_o = item_i.wifi_state;
    end else if (idx_i <= POS_SEQ_HI) begin
      byte_o = item_i.sequence_number[{seq_sel, 3'b000} +: 8];
    end else if (idx_i <= POS_RESV_LAST) begin
      byte_o = cfg_i.reserved_word[{res_sel, 3'b000} +: 8];
    end else if (idx_i == POS_LEN_LO) begin
      byte_o = item_i.body_length[7:0];
    end else begin
      byte_o = item_i.body_length[15:8];
    end
  end

endmodule

`default_nettype wire

@@ rtl/cxf_core.sv @@
// Word register, byte sequencer, CRC state and output register.
`default_nettype none

module cxf_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cxf_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire cxf_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cxf_pkg::out_word_t     out_word_o
);
  import cxf_pkg::*;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  in_word_t   item_q;
  logic [15:0] rem_q, rem_d;
  logic [15:0] body_crc_q, body_crc_d;
  logic [15:0] frame_crc_q, frame_crc_d;
  logic        empty_q, empty_d;
  logic        out_valid_q;
  out_word_t   out_word_q, out_word_d;

  logic        room, adv, accept, item_done, framed;
  logic [7:0]  hdr_byte, step_byte;
  logic [15:0] slot;
  tail_slot_e  tail_slot;

  cxf_hdr_sel u_hdr_sel (
    .idx_i  (cnt_q),
    .item_i (item_q),
    .cfg_i  (cfg_i),
    .byte_o (hdr_byte)
  );

  assign room       = !out_valid_q || !out_stall_i;
  assign adv        = (state_q != ST_IDLE) && room;
  assign in_stall_o = (state_q != ST_IDLE) && !(adv && item_done);
  assign accept     = in_valid_i && !in_stall_o;
  assign tail_slot  = tail_slot_e'(cnt_q[1:0]);
  assign slot       = empty_q ? 16'h0000 : ~body_crc_q;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (adv) begin
      unique case (state_q)
        ST_HEAD: begin
          if (cnt_q == HDR_LAST) begin
            cnt_d   = '0;
            state_d = (item_q.body_length == 16'd0) ? ST_TAIL : ST_IDLE;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        ST_BODY: begin
          cnt_d   = '0;
          state_d = (rem_q == 16'd1) ? ST_TAIL : ST_IDLE;
        end
        ST_TAIL: begin
          if (tail_slot == TL_FRAME_HI) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
    if (accept) begin
      cnt_d   = '0;
      state_d = in_word_i.mode ? ST_BODY : ST_HEAD;
    end
  end

  // byte of the current step and CRC/count updates
  always_comb begin
    step_byte   = '0;
    framed      = 1'b0;
    item_done   = 1'b0;
    out_word_d  = '0;
    rem_d       = rem_q;
    body_crc_d  = body_crc_q;
    frame_crc_d = frame_crc_q;
    empty_d     = empty_q;
    unique case (state_q)
      ST_HEAD: begin
        step_byte = hdr_byte;
        item_done = (cnt_q == HDR_LAST) && (item_q.body_length != 16'd0);
        if (cnt_q == '0) begin
          frame_crc_d = CRC_INIT;
          body_crc_d  = CRC_INIT;
          rem_d       = item_q.body_length;
        end else begin
          framed = 1'b1;
        end
        empty_d = (item_q.body_length == 16'd0);
      end
      ST_BODY: begin
        if (rem_q == 16'd0) begin
          item_done          = 1'b1;
          out_word_d.overrun = 1'b1;
        end else begin
          step_byte  = item_q.body_byte;
          framed     = 1'b1;
          body_crc_d = crc_byte(body_crc_q, item_q.body_byte);
          rem_d      = rem_q - 16'd1;
          item_done  = (rem_q != 16'd1);
          empty_d    = 1'b0;
        end
      end
      ST_TAIL: begin
        unique case (tail_slot)
          TL_BODY_LO: begin
            step_byte = slot[7:0];
            framed    = 1'b1;
          end
          TL_BODY_HI: begin
            step_byte = slot[15:8];
            framed    = 1'b1;
          end
          TL_FRAME_LO: begin
            step_byte = ~frame_crc_q[7:0];
          end
          TL_FRAME_HI: begin
            step_byte            = ~frame_crc_q[15:8];
            out_word_d.frame_end = 1'b1;
            item_done            = 1'b1;
            rem_d                = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (framed) begin
      frame_crc_d = crc_byte(frame_crc_q, step_byte);
    end
    out_word_d.out_byte = step_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      body_crc_q  <= CRC_INIT;
      frame_crc_q <= CRC_INIT;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (adv) begin
        rem_q       <= rem_d;
        body_crc_q  <= body_crc_d;
        frame_crc_q <= frame_crc_d;
        empty_q     <= empty_d;
      end
      if (room) begin
        out_valid_q <= adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    if (adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

@@ rtl/cxf_checker.sv @@
// Port-level checks of the frame builder and their bind.
`default_nettype none
`include "crc16_x25_frame_builder_top_macros.svh"

module cxf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire cxf_pkg::in_word_t  in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire cxf_pkg::out_word_t out_word_o
);
  import cxf_pkg::*;

  `CXF_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")
  `CXF_ASSERT_IMP(a_ovr_clean, out_valid_o && out_word_o.overrun, !out_word_o.frame_end && (out_word_o.out_byte == 8'h00), "overrun word carries data")
  `CXF_ASSERT_NXT(a_hdr_holds, in_valid_i && !in_stall_o && !in_word_i.mode, in_stall_o, "input open right after a start word")
  `CXF_ASSERT_NXT(a_end_single, out_valid_o && !out_stall_i && out_word_o.frame_end, !(out_valid_o && out_word_o.frame_end), "two frame ends in a row")

endmodule

bind crc16_x25_frame_builder_top cxf_checker u_cxf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
